[src/bap_pkg.sv]
package bap_pkg;

	localparam logic [3:0] K_DELAY      = 4'd0;
	localparam logic [3:0] K_NSUB       = 4'd1;
	localparam logic [3:0] K_NBIS       = 4'd2;
	localparam logic [3:0] K_FORMAT     = 4'd3;
	localparam logic [3:0] K_COMPANY    = 4'd4;
	localparam logic [3:0] K_VENDOR     = 4'd5;
	localparam logic [3:0] K_CFGLEN     = 4'd6;
	localparam logic [3:0] K_CFGBYTE    = 4'd7;
	localparam logic [3:0] K_METALEN    = 4'd8;
	localparam logic [3:0] K_METABYTE   = 4'd9;
	localparam logic [3:0] K_BISIDX     = 4'd10;
	localparam logic [3:0] K_BISCFGLEN  = 4'd11;
	localparam logic [3:0] K_BISCFGBYTE = 4'd12;
	localparam logic [3:0] K_TRAIL      = 4'd13;
	localparam logic [3:0] K_ERROR      = 4'd14;

	localparam logic [2:0] ST_BUSY      = 3'd0;
	localparam logic [2:0] ST_OK        = 3'd1;
	localparam logic [2:0] ST_TRUNC     = 3'd2;
	localparam logic [2:0] ST_NO_SUB    = 3'd3;
	localparam logic [2:0] ST_NO_BIS    = 3'd4;
	localparam logic [2:0] ST_TOO_LONG  = 3'd5;

	localparam logic [8:0] MAX_BYTES    = 9'd255;
	localparam logic [8:0] BYTES_SAT    = 9'd256;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_t;

	typedef struct packed {
		logic [3:0]  field_kind;
		logic [7:0]  subgroup_number;
		logic [7:0]  bis_number;
		logic [7:0]  byte_in_field;
		logic [23:0] field_value;
		logic        field_complete;
		logic [2:0]  parse_status;
		logic        buffer_end;
	} tag_t;

endpackage

[src/bap_byte_if.sv]
interface bap_byte_if;
	logic            valid;
	logic            ready;
	bap_pkg::byte_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/bap_tag_if.sv]
interface bap_tag_if;
	logic           valid;
	logic           ready;
	bap_pkg::tag_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/broadcast_audio_base_parser_core.sv]
// Channel  | Direction | Beat payload
// ---------+-----------+---------------------------------------------------
// bytes    | in        | data_byte, last_byte
// tags     | out       | field_kind, subgroup_number, bis_number, byte_in_field,
//          |           | field_value, field_complete, parse_status, buffer_end
//
// One beat in gives exactly one beat out; a byte is taken every cycle while tags does not stall.
// A byte passes through an input register, then through the parse logic and the
// parser state update into the result register.
// While a finished tag waits at tags, the input register takes at most one more byte and then holds.
// arst_n clears both stages and all parser state; last_byte returns it to reset.
module broadcast_audio_base_parser_core (
	input  logic         clk,
	input  logic         arst_n,
	bap_byte_if.sink     bytes,
	bap_tag_if.source    tags
);

	logic               in_valid_s1;
	bap_pkg::byte_t     in_s1;
	logic               out_valid_s2;
	bap_pkg::tag_t      out_s2;
	logic               advance;

	logic [3:0]  phase_q;
	logic [7:0]  byte_pos_q;
	logic [7:0]  len_left_q;
	logic [7:0]  sub_left_q;
	logic [7:0]  bis_left_q;
	logic [7:0]  sub_cnt_q;
	logic [7:0]  bis_cnt_q;
	logic [23:0] acc_q;
	logic [8:0]  total_q;
	logic [2:0]  err_q;

	logic [3:0]  phase_d;
	logic [7:0]  byte_pos_d;
	logic [7:0]  len_left_d;
	logic [7:0]  sub_left_d;
	logic [7:0]  bis_left_d;
	logic [7:0]  sub_cnt_d;
	logic [7:0]  bis_cnt_d;
	logic [23:0] acc_d;
	logic [8:0]  total_d;
	logic [2:0]  err_d;
	bap_pkg::tag_t tag_d;

	assign advance = in_valid_s1 && (!out_valid_s2 || tags.ready);
	assign bytes.ready = !in_valid_s1 || advance;
	assign tags.valid = out_valid_s2;
	assign tags.data = out_s2;

	always_comb begin
		logic [7:0]  b;
		logic [3:0]  kind;
		logic [7:0]  sg;
		logic [7:0]  bn;
		logic [7:0]  bif;
		logic [23:0] val;
		logic        done;
		logic [23:0] shifted;
		logic        bis_end;

		b = in_s1.data_byte;
		phase_d = phase_q;
		byte_pos_d = byte_pos_q;
		len_left_d = len_left_q;
		sub_left_d = sub_left_q;
		bis_left_d = bis_left_q;
		sub_cnt_d = sub_cnt_q;
		bis_cnt_d = bis_cnt_q;
		acc_d = acc_q;
		total_d = total_q;
		err_d = err_q;
		done = 1'b0;
		val = {16'd0, b};
		shifted = 24'd0;
		bis_end = 1'b0;

		// The 256th byte of a buffer overflows unless an error is already set.
		if (err_q == bap_pkg::ST_BUSY && total_q >= bap_pkg::MAX_BYTES) begin
			err_d = bap_pkg::ST_TOO_LONG;
			phase_d = bap_pkg::K_ERROR;
			byte_pos_d = 8'd0;
			acc_d = 24'd0;
		end
		if (total_q < bap_pkg::BYTES_SAT) begin
			total_d = total_q + 9'd1;
		end

		kind = phase_d;
		sg = (kind <= bap_pkg::K_NSUB) ? 8'd0 : sub_cnt_q;
		bn = (kind >= bap_pkg::K_BISIDX && kind <= bap_pkg::K_BISCFGBYTE) ?
			bis_cnt_q : 8'd0;
		bif = byte_pos_d;

		case (kind)
			bap_pkg::K_DELAY, bap_pkg::K_COMPANY, bap_pkg::K_VENDOR: begin
				case (byte_pos_d[1:0])
					2'd0: shifted = {16'd0, b};
					2'd1: shifted = {8'd0, b, 8'd0};
					2'd2: shifted = {b, 16'd0};
					default: shifted = 24'd0;
				endcase
				acc_d = acc_d | shifted;
				val = acc_d;
				byte_pos_d = byte_pos_d + 8'd1;
				if (byte_pos_d >= ((kind == bap_pkg::K_DELAY) ? 8'd3 : 8'd2)) begin
					done = 1'b1;
					phase_d = kind + 4'd1;
					byte_pos_d = 8'd0;
					acc_d = 24'd0;
				end
			end
			bap_pkg::K_NSUB: begin
				done = 1'b1;
				byte_pos_d = 8'd0;
				acc_d = 24'd0;
				if (b == 8'd0) begin
					err_d = bap_pkg::ST_NO_SUB;
					phase_d = bap_pkg::K_ERROR;
				end else begin
					sub_left_d = b;
					sub_cnt_d = 8'd0;
					phase_d = bap_pkg::K_NBIS;
				end
			end
			bap_pkg::K_NBIS: begin
				done = 1'b1;
				byte_pos_d = 8'd0;
				acc_d = 24'd0;
				if (b == 8'd0) begin
					err_d = bap_pkg::ST_NO_BIS;
					phase_d = bap_pkg::K_ERROR;
				end else begin
					bis_left_d = b;
					bis_cnt_d = 8'd0;
					phase_d = bap_pkg::K_FORMAT;
				end
			end
			bap_pkg::K_FORMAT, bap_pkg::K_BISIDX: begin
				done = 1'b1;
				byte_pos_d = 8'd0;
				acc_d = 24'd0;
				phase_d = kind + 4'd1;
			end
			bap_pkg::K_CFGLEN: begin
				done = 1'b1;
				len_left_d = b;
				byte_pos_d = 8'd0;
				acc_d = 24'd0;
				phase_d = (b != 8'd0) ? bap_pkg::K_CFGBYTE : bap_pkg::K_METALEN;
			end
			bap_pkg::K_METALEN: begin
				done = 1'b1;
				len_left_d = b;
				byte_pos_d = 8'd0;
				acc_d = 24'd0;
				phase_d = (b != 8'd0) ? bap_pkg::K_METABYTE : bap_pkg::K_BISIDX;
			end
			bap_pkg::K_BISCFGLEN: begin
				done = 1'b1;
				len_left_d = b;
				byte_pos_d = 8'd0;
				acc_d = 24'd0;
				if (b != 8'd0) begin
					phase_d = bap_pkg::K_BISCFGBYTE;
				end else begin
					bis_end = 1'b1;
				end
			end
			bap_pkg::K_CFGBYTE, bap_pkg::K_METABYTE, bap_pkg::K_BISCFGBYTE: begin
				len_left_d = len_left_q - 8'd1;
				byte_pos_d = byte_pos_d + 8'd1;
				if (len_left_d == 8'd0) begin
					done = 1'b1;
					byte_pos_d = 8'd0;
					acc_d = 24'd0;
					case (kind)
						bap_pkg::K_CFGBYTE: phase_d = bap_pkg::K_METALEN;
						bap_pkg::K_METABYTE: phase_d = bap_pkg::K_BISIDX;
						default: bis_end = 1'b1;
					endcase
				end
			end
			default: begin
				sg = 8'd0;
				bn = 8'd0;
				bif = 8'd0;
				val = 24'd0;
			end
		endcase

		// Closing a BIS moves to the next BIS, the next subgroup or the trailer.
		if (bis_end) begin
			bis_left_d = bis_left_q - 8'd1;
			if (bis_left_d != 8'd0) begin
				bis_cnt_d = bis_cnt_q + 8'd1;
				phase_d = bap_pkg::K_BISIDX;
			end else begin
				bis_cnt_d = 8'd0;
				sub_left_d = sub_left_q - 8'd1;
				sub_cnt_d = sub_cnt_q + 8'd1;
				phase_d = (sub_left_d != 8'd0) ? bap_pkg::K_NBIS : bap_pkg::K_TRAIL;
			end
		end

		tag_d.field_kind = kind;
		tag_d.subgroup_number = sg;
		tag_d.bis_number = bn;
		tag_d.byte_in_field = bif;
		tag_d.field_value = val;
		tag_d.field_complete = done;
		tag_d.buffer_end = in_s1.last_byte;
		if (err_d != bap_pkg::ST_BUSY) begin
			tag_d.parse_status = err_d;
		end else if (phase_d == bap_pkg::K_TRAIL) begin
			tag_d.parse_status = bap_pkg::ST_OK;
		end else if (in_s1.last_byte) begin
			tag_d.parse_status = bap_pkg::ST_TRUNC;
		end else begin
			tag_d.parse_status = bap_pkg::ST_BUSY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (bytes.ready) begin
				in_valid_s1 <= bytes.valid;
			end
			if (advance) begin
				out_valid_s2 <= 1'b1;
			end else if (tags.ready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			in_s1 <= bytes.data;
		end
		if (advance) begin
			out_s2 <= tag_d;
		end
	end

	// Parser state; the last byte of a buffer puts it back to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bap_pkg::K_DELAY;
			byte_pos_q <= 8'd0;
			len_left_q <= 8'd0;
			sub_left_q <= 8'd0;
			bis_left_q <= 8'd0;
			sub_cnt_q <= 8'd0;
			bis_cnt_q <= 8'd0;
			acc_q <= 24'd0;
			total_q <= 9'd0;
			err_q <= bap_pkg::ST_BUSY;
		end else if (advance) begin
			if (in_s1.last_byte) begin
				phase_q <= bap_pkg::K_DELAY;
				byte_pos_q <= 8'd0;
				len_left_q <= 8'd0;
				sub_left_q <= 8'd0;
				bis_left_q <= 8'd0;
				sub_cnt_q <= 8'd0;
				bis_cnt_q <= 8'd0;
				acc_q <= 24'd0;
				total_q <= 9'd0;
				err_q <= bap_pkg::ST_BUSY;
			end else begin
				phase_q <= phase_d;
				byte_pos_q <= byte_pos_d;
				len_left_q <= len_left_d;
				sub_left_q <= sub_left_d;
				bis_left_q <= bis_left_d;
				sub_cnt_q <= sub_cnt_d;
				bis_cnt_q <= bis_cnt_d;
				acc_q <= acc_d;
				total_q <= total_d;
				err_q <= err_d;
			end
		end
	end

endmodule

[test/broadcast_audio_base_parser_core_test.sv]
module broadcast_audio_base_parser_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] NO_ERROR      = 3'd0;
	localparam int         DIRECTED_ROWS = 31;
	localparam int         PHASE_ITEMS   = 600;
	localparam int         QUIET_LIMIT   = 2000;
	localparam int         DRAIN_CYCLES  = 8;
	localparam int         PRINT_LIMIT   = 40;

	typedef struct {
		logic [7:0]    data;
		logic          last;
		bit            typed;
		bap_pkg::tag_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	bap_byte_if byte_bus ();
	bap_tag_if  tag_bus ();

	broadcast_audio_base_parser_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_bus),
		.tags   (tag_bus)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Parser state kept alongside the block.
	logic [3:0]  base_phase;
	logic [7:0]  field_pos;
	logic [7:0]  bytes_left;
	logic [7:0]  subgroups_left;
	logic [7:0]  bis_left;
	logic [7:0]  subgroup_idx;
	logic [7:0]  bis_idx;
	logic [23:0] value_acc;
	logic [8:0]  buffer_count;
	logic [2:0]  parse_err;

	bap_pkg::tag_t expected_tags[$];
	logic [7:0]  base_buf[$];
	int          parsed_items;
	int          mismatches;
	int          tag_beats;
	int          quiet_cycles;
	int          send_idle_pct;
	int          recv_stall_pct;

	// Structure A is a full BASE with one subgroup and two BISes, the first with an
	// empty configuration, then one trailing byte. B has no subgroups, C has no
	// BIS in its subgroup, and D ends after a single byte.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{8'hFF, 1'b0, 1'b1, {bap_pkg::K_DELAY, 8'd0, 8'd0, 8'd0, 24'h0000FF, 1'b0,
			bap_pkg::ST_BUSY, 1'b0}},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, '0},
		'{8'h02, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h34, 1'b0, 1'b0, '0},
		'{8'h12, 1'b0, 1'b0, '0},
		'{8'hCD, 1'b0, 1'b0, '0},
		'{8'hAB, 1'b0, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, '0},
		'{8'h5A, 1'b0, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, '0},
		'{8'hC3, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'hEE, 1'b1, 1'b1, {bap_pkg::K_TRAIL, 8'd0, 8'd0, 8'd0, 24'h0, 1'b0,
			bap_pkg::ST_OK, 1'b1}},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b1, 1'b1, {bap_pkg::K_NSUB, 8'd0, 8'd0, 8'd0, 24'h0, 1'b1,
			bap_pkg::ST_NO_SUB, 1'b1}},
		'{8'h12, 1'b0, 1'b0, '0},
		'{8'h34, 1'b0, 1'b0, '0},
		'{8'h56, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b1, {bap_pkg::K_NBIS, 8'd0, 8'd0, 8'd0, 24'h0, 1'b1,
			bap_pkg::ST_NO_BIS, 1'b0}},
		'{8'h7F, 1'b1, 1'b1, {bap_pkg::K_ERROR, 8'd0, 8'd0, 8'd0, 24'h0, 1'b0,
			bap_pkg::ST_NO_BIS, 1'b1}},
		'{8'hA5, 1'b1, 1'b1, {bap_pkg::K_DELAY, 8'd0, 8'd0, 8'd0, 24'h0000A5, 1'b0,
			bap_pkg::ST_TRUNC, 1'b1}}
	};

	task automatic enter_field(input logic [3:0] next);
		base_phase = next;
		field_pos  = 8'd0;
		value_acc  = 24'd0;
	endtask

	task automatic raise_error(input logic [2:0] code);
		parse_err = code;
		enter_field(bap_pkg::K_ERROR);
	endtask

	task automatic clear_parser();
		enter_field(bap_pkg::K_DELAY);
		bytes_left     = 8'd0;
		subgroups_left = 8'd0;
		bis_left       = 8'd0;
		subgroup_idx   = 8'd0;
		bis_idx        = 8'd0;
		buffer_count   = 9'd0;
		parse_err      = NO_ERROR;
	endtask

	task automatic close_bis();
		bis_left--;
		bis_idx++;
		if (bis_left != 8'd0) begin
			enter_field(bap_pkg::K_BISIDX);
		end else begin
			bis_idx = 8'd0;
			subgroups_left--;
			subgroup_idx++;
			enter_field((subgroups_left != 8'd0) ? bap_pkg::K_NBIS : bap_pkg::K_TRAIL);
		end
	endtask

	// Consumes one byte of a length-prefixed string; true on its final byte.
	function automatic logic take_string_byte();
		bytes_left--;
		field_pos++;
		return bytes_left == 8'd0;
	endfunction

	task automatic tag_byte(input logic [7:0] b, input logic last,
			output bap_pkg::tag_t t);
		logic [3:0]  kind;
		logic [7:0]  sg;
		logic [7:0]  bn;
		logic [7:0]  pos;
		logic [23:0] val;
		logic        done;
		logic [2:0]  status;
		if (parse_err == NO_ERROR && buffer_count >= bap_pkg::MAX_BYTES)
			raise_error(bap_pkg::ST_TOO_LONG);
		if (buffer_count < bap_pkg::BYTES_SAT)
			buffer_count++;
		kind = base_phase;
		sg   = (kind <= bap_pkg::K_NSUB) ? 8'd0 : subgroup_idx;
		bn   = (kind >= bap_pkg::K_BISIDX && kind <= bap_pkg::K_BISCFGBYTE) ?
			bis_idx : 8'd0;
		pos  = field_pos;
		val  = {16'd0, b};
		done = 1'b0;
		case (kind)
		bap_pkg::K_DELAY, bap_pkg::K_COMPANY, bap_pkg::K_VENDOR: begin
			value_acc = value_acc | (24'(b) << (8 * field_pos[1:0]));
			val = value_acc;
			field_pos++;
			if (field_pos >= ((kind == bap_pkg::K_DELAY) ? 8'd3 : 8'd2)) begin
				done = 1'b1;
				enter_field(kind + 4'd1);
			end
		end
		bap_pkg::K_NSUB: begin
			done = 1'b1;
			if (b == 8'd0) begin
				raise_error(bap_pkg::ST_NO_SUB);
			end else begin
				subgroups_left = b;
				subgroup_idx   = 8'd0;
				enter_field(bap_pkg::K_NBIS);
			end
		end
		bap_pkg::K_NBIS: begin
			done = 1'b1;
			if (b == 8'd0) begin
				raise_error(bap_pkg::ST_NO_BIS);
			end else begin
				bis_left = b;
				bis_idx  = 8'd0;
				enter_field(bap_pkg::K_FORMAT);
			end
		end
		bap_pkg::K_FORMAT: begin
			done = 1'b1;
			enter_field(bap_pkg::K_COMPANY);
		end
		bap_pkg::K_CFGLEN: begin
			done = 1'b1;
			bytes_left = b;
			enter_field((b != 8'd0) ? bap_pkg::K_CFGBYTE : bap_pkg::K_METALEN);
		end
		bap_pkg::K_CFGBYTE: begin
			if (take_string_byte()) begin
				done = 1'b1;
				enter_field(bap_pkg::K_METALEN);
			end
		end
		bap_pkg::K_METALEN: begin
			done = 1'b1;
			bytes_left = b;
			enter_field((b != 8'd0) ? bap_pkg::K_METABYTE : bap_pkg::K_BISIDX);
		end
		bap_pkg::K_METABYTE: begin
			if (take_string_byte()) begin
				done = 1'b1;
				enter_field(bap_pkg::K_BISIDX);
			end
		end
		bap_pkg::K_BISIDX: begin
			done = 1'b1;
			enter_field(bap_pkg::K_BISCFGLEN);
		end
		bap_pkg::K_BISCFGLEN: begin
			done = 1'b1;
			bytes_left = b;
			if (b != 8'd0)
				enter_field(bap_pkg::K_BISCFGBYTE);
			else
				close_bis();
		end
		bap_pkg::K_BISCFGBYTE: begin
			if (take_string_byte()) begin
				done = 1'b1;
				close_bis();
			end
		end
		default: begin
			sg  = 8'd0;
			bn  = 8'd0;
			pos = 8'd0;
			val = 24'd0;
		end
		endcase
		if (parse_err != NO_ERROR)
			status = parse_err;
		else if (base_phase == bap_pkg::K_TRAIL)
			status = bap_pkg::ST_OK;
		else if (last)
			status = bap_pkg::ST_TRUNC;
		else
			status = bap_pkg::ST_BUSY;
		t = {kind, sg, bn, pos, val, done, status, last};
		if (last)
			clear_parser();
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("MISMATCH at %0t ns, tag beat %0d: %s", $time, tag_beats, what);
	endtask

	task automatic check_field(input string name, input logic [23:0] got,
			input logic [23:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
			input bap_pkg::tag_t want);
		bap_pkg::tag_t predicted;
		@(negedge clk);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			byte_bus.valid <= 1'b0;
			@(negedge clk);
		end
		byte_bus.valid <= 1'b1;
		byte_bus.data  <= {b, last};
		do
			@(posedge clk);
		while (byte_bus.ready !== 1'b1);
		tag_byte(b, last, predicted);
		expected_tags.push_back(typed ? want : predicted);
		if (predicted.field_kind < bap_pkg::K_TRAIL)
			parsed_items++;
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		byte_bus.valid <= 1'b0;
		while (expected_tags.size() != 0)
			@(posedge clk);
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(99, 0);
		if (r < 25)
			return 0;
		if (r < 97)
			return $urandom_range(6, 1);
		return $urandom_range(255, 200);
	endfunction

	// Mostly well-formed structures with random content; some are cut short, some
	// run past 255 bytes, some carry zero counts, and a few are plain noise.
	task automatic build_buffer();
		int shape;
		int n_sub;
		int n_bis;
		int len;
		int cut;
		int pad_to;
		base_buf.delete();
		shape = $urandom_range(99, 0);
		if (shape < 5) begin
			repeat ($urandom_range(20, 1))
				base_buf.push_back(8'($urandom));
			return;
		end
		repeat (3)
			base_buf.push_back(8'($urandom));
		n_sub = ($urandom_range(19, 0) == 0) ? 0 : $urandom_range(3, 1);
		base_buf.push_back(8'(n_sub));
		for (int s = 0; s < n_sub; s++) begin
			n_bis = ($urandom_range(24, 0) == 0) ? 0 : $urandom_range(3, 1);
			base_buf.push_back(8'(n_bis));
			if (n_bis == 0)
				break;
			repeat (5)
				base_buf.push_back(8'($urandom));
			repeat (2) begin
				len = pick_len();
				base_buf.push_back(8'(len));
				repeat (len)
					base_buf.push_back(8'($urandom));
			end
			repeat (n_bis) begin
				base_buf.push_back(8'($urandom));
				len = pick_len();
				base_buf.push_back(8'(len));
				repeat (len)
					base_buf.push_back(8'($urandom));
			end
		end
		if (shape < 20 && base_buf.size() > 1) begin
			cut = $urandom_range(base_buf.size() - 1, 1);
			while (base_buf.size() > cut)
				void'(base_buf.pop_back());
		end else if (shape < 25) begin
			pad_to = $urandom_range(300, 256);
			while (base_buf.size() < pad_to)
				base_buf.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(2, 0))
				base_buf.push_back(8'($urandom));
		end
	endtask

	initial begin
		tag_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			tag_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : check_tags
		bap_pkg::tag_t want;
		if (arst_n && tag_bus.valid === 1'b1 && tag_bus.ready === 1'b1) begin
			tag_beats++;
			if (expected_tags.size() == 0) begin
				report_mismatch("tag beat with no byte outstanding");
			end else begin
				want = expected_tags.pop_front();
				check_field("field_kind", 24'(tag_bus.data.field_kind), 24'(want.field_kind));
				check_field("subgroup_number", 24'(tag_bus.data.subgroup_number),
					24'(want.subgroup_number));
				check_field("bis_number", 24'(tag_bus.data.bis_number), 24'(want.bis_number));
				check_field("byte_in_field", 24'(tag_bus.data.byte_in_field),
					24'(want.byte_in_field));
				check_field("field_value", tag_bus.data.field_value, want.field_value);
				check_field("field_complete", 24'(tag_bus.data.field_complete),
					24'(want.field_complete));
				check_field("parse_status", 24'(tag_bus.data.parse_status),
					24'(want.parse_status));
				check_field("buffer_end", 24'(tag_bus.data.buffer_end), 24'(want.buffer_end));
			end
		end
	end

	// Ends the run when neither channel moves a beat for too long.
	always @(posedge clk) begin
		if ((byte_bus.valid === 1'b1 && byte_bus.ready === 1'b1) ||
				(tag_bus.valid === 1'b1 && tag_bus.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		int target;
		arst_n         = 1'b0;
		byte_bus.valid = 1'b0;
		byte_bus.data  = '0;
		parsed_items   = 0;
		mismatches     = 0;
		tag_beats      = 0;
		quiet_cycles   = 0;
		send_idle_pct  = 32;
		recv_stall_pct = 86;
		clear_parser();
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
				directed_rows[i].want);
		wait_for_results();

		for (int p = 0; p < 3; p++) begin
			send_idle_pct  = (p == 0) ? 32 : (p == 1) ? 86 : 0;
			recv_stall_pct = (p == 0) ? 86 : (p == 1) ? 32 : 0;
			target = parsed_items + PHASE_ITEMS;
			while (parsed_items < target) begin
				build_buffer();
				for (int i = 0; i < base_buf.size(); i++)
					send_byte(base_buf[i], (i == base_buf.size() - 1), 1'b0, '0);
			end
			wait_for_results();
		end

		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[broadcast_audio_base_parser_core.f]
src/bap_pkg.sv
src/bap_byte_if.sv
src/bap_tag_if.sv
src/broadcast_audio_base_parser_core.sv
test/broadcast_audio_base_parser_core_test.sv
